// File: src/tccw_pkg.sv
package tccw_pkg;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_RETURN   = 8'h0D;
    localparam logic [7:0] CH_BACK     = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h0F;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  text_color;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_color;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clr_start;
        logic fill_step;
        logic store;
        logic store_space;
        logic tab_load;
        logic adv;
        logic col_home;
        logic col_dec;
        logic blank;
        logic rd_issue;
        logic out_load;
        logic out_rd;
        logic out_take;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       is_nl;
        logic       is_cr;
        logic       is_bs;
        logic       is_tab;
        logic       col_zero;
        logic       col_last;
        logic       row_last;
        logic       tab_last;
        logic       tab_more;
        logic       fill_last;
    } t_sts;

endpackage

// File: src/tccw_ctrl.sv
module tccw_ctrl import tccw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_STORE  = 4'd3;
    localparam logic [3:0] S_TAB    = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_BLANK  = 4'd6;
    localparam logic [3:0] S_RDATA  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.req)
                    REQ_PUT: begin
                        if (i_sts.is_nl) begin
                            o_cmd.adv = 1'b1;
                            n_state   = i_sts.row_last ? S_FILL : S_DONE;
                        end else if (i_sts.is_cr) begin
                            o_cmd.col_home = 1'b1;
                            n_state        = S_DONE;
                        end else if (i_sts.is_bs) begin
                            if (i_sts.col_zero) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.col_dec = 1'b1;
                                n_state       = S_BLANK;
                            end
                        end else if (i_sts.is_tab) begin
                            o_cmd.tab_load = 1'b1;
                            n_state        = S_TAB;
                        end else begin
                            n_state = S_STORE;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_FILL;
                    end
                    REQ_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RDATA;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = (i_sts.col_last && i_sts.row_last) ? S_FILL : S_DONE;
            end
            S_TAB: begin
                o_cmd.store       = 1'b1;
                o_cmd.store_space = 1'b1;
                if (i_sts.col_last && i_sts.row_last) begin
                    n_state = S_FILL;
                end else if (i_sts.tab_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TAB;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    // resume a tab that wrapped into a scroll
                    n_state = (i_sts.is_tab && i_sts.tab_more) ? S_TAB : S_DONE;
                end
            end
            S_BLANK: begin
                o_cmd.blank = 1'b1;
                n_state     = S_DONE;
            end
            S_RDATA: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_rd   = 1'b1;
                n_state        = S_OUT;
            end
            S_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    o_cmd.out_take = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_DECODE))
        else $error("capture did not lead to decode");

    a_fill_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && !i_sts.fill_last) |=> (r_state == S_FILL))
        else $error("fill sweep left early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_stall) |=> (r_state == S_OUT))
        else $error("result dropped while stalled");

endmodule

// File: src/tccw_dpath.sv
module tccw_dpath import tccw_pkg::*; #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int FW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int TW    = $clog2(TAB_STOP + 1);
    localparam int SW    = ((AW > 11) ? AW : 11) + 1;

    logic [7:0] char_mem  [CELLS];
    logic [7:0] color_mem [CELLS];

    t_in_item        r_item;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [PW-1:0]   r_ph;
    logic [TW-1:0]   r_tab_left;
    logic [AW-1:0]   r_row_base;
    logic [AW-1:0]   r_top_off;
    logic [AW-1:0]   r_fill_addr;
    logic [FW-1:0]   r_fill_left;
    logic [7:0]      r_fill_color;
    logic [7:0]      r_rd_char;
    logic [7:0]      r_rd_color;
    logic            r_in_range;
    logic            r_out_valid;
    t_out_item       r_out;

    logic [AW:0]     cur_sum;
    logic [AW-1:0]   cur_addr;
    logic [AW:0]     rb_sum;
    logic [AW-1:0]   rb_next;
    logic [AW:0]     top_sum;
    logic [AW-1:0]   top_next;
    logic [SW-1:0]   rd_sum;
    logic [AW-1:0]   rd_addr;
    logic            rd_in_range;
    logic            col_last;
    logic            row_last;
    logic            do_adv;
    logic [PW-1:0]   ph_inc;
    logic [PW-1:0]   ph_dec;
    logic            we_char;
    logic            we_color;
    logic [AW-1:0]   w_addr;
    logic [7:0]      w_char;
    logic [7:0]      w_color;

    // rows live in a ring; r_top_off is the physical start of screen row zero
    assign cur_sum  = (AW+1)'(r_row_base) + (AW+1)'(r_col);
    assign cur_addr = (cur_sum >= (AW+1)'(CELLS)) ? AW'(cur_sum - (AW+1)'(CELLS))
                                                   : AW'(cur_sum);
    assign rb_sum   = (AW+1)'(r_row_base) + (AW+1)'(COLS);
    assign rb_next  = (rb_sum >= (AW+1)'(CELLS)) ? AW'(rb_sum - (AW+1)'(CELLS))
                                                  : AW'(rb_sum);
    assign top_sum  = (AW+1)'(r_top_off) + (AW+1)'(COLS);
    assign top_next = (top_sum >= (AW+1)'(CELLS)) ? AW'(top_sum - (AW+1)'(CELLS))
                                                   : AW'(top_sum);

    assign rd_in_range = (SW'(r_item.cell_index) < SW'(CELLS));
    assign rd_sum      = SW'(r_item.cell_index) + SW'(r_top_off);
    assign rd_addr     = (rd_sum >= SW'(CELLS)) ? AW'(rd_sum - SW'(CELLS)) : AW'(rd_sum);

    assign col_last = (r_col == CW'(COLS - 1));
    assign row_last = (r_row == RW'(ROWS - 1));
    assign do_adv   = i_cmd.adv || (i_cmd.store && col_last);
    assign ph_inc   = (r_ph == PW'(TAB_STOP - 1)) ? '0 : PW'(r_ph + 1'b1);
    assign ph_dec   = (r_ph == '0) ? PW'(TAB_STOP - 1) : PW'(r_ph - 1'b1);

    always_comb begin
        we_char  = 1'b0;
        we_color = 1'b0;
        w_addr   = cur_addr;
        w_char   = CH_SPACE;
        w_color  = r_item.text_color;
        priority if (i_cmd.fill_step) begin
            we_char  = 1'b1;
            we_color = 1'b1;
            w_addr   = r_fill_addr;
            w_color  = r_fill_color;
        end else if (i_cmd.store) begin
            we_char  = 1'b1;
            we_color = 1'b1;
            w_char   = i_cmd.store_space ? CH_SPACE : r_item.char_code;
        end else if (i_cmd.blank) begin
            we_char = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_char) char_mem[w_addr] <= w_char;
        if (we_color) color_mem[w_addr] <= w_color;
        if (i_cmd.rd_issue) begin
            r_rd_char  <= char_mem[rd_addr];
            r_rd_color <= color_mem[rd_addr];
            r_in_range <= rd_in_range;
        end
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.out_load) begin
            r_out.cursor_col <= 7'(r_col);
            r_out.cursor_row <= 5'(r_row);
            r_out.read_char  <= (i_cmd.out_rd && r_in_range) ? r_rd_char : '0;
            r_out.read_color <= (i_cmd.out_rd && r_in_range) ? r_rd_color : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_ph         <= '0;
            r_tab_left   <= '0;
            r_row_base   <= '0;
            r_top_off    <= '0;
            r_fill_addr  <= '0;
            r_fill_left  <= FW'(CELLS);
            r_fill_color <= RESET_COLOR;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.capture) r_fill_color <= i_item.text_color;
            if (i_cmd.clr_start) begin
                r_col       <= '0;
                r_row       <= '0;
                r_ph        <= '0;
                r_row_base  <= '0;
                r_top_off   <= '0;
                r_fill_addr <= '0;
                r_fill_left <= FW'(CELLS);
            end
            if (i_cmd.fill_step) begin
                r_fill_addr <= AW'(r_fill_addr + 1'b1);
                r_fill_left <= FW'(r_fill_left - 1'b1);
            end
            if (i_cmd.tab_load) r_tab_left <= TW'(TAB_STOP) - TW'(r_ph);
            if (i_cmd.store_space) r_tab_left <= TW'(r_tab_left - 1'b1);
            if (do_adv) begin
                r_col      <= '0;
                r_ph       <= '0;
                r_row_base <= rb_next;
                if (row_last) begin
                    // scroll: the old top row becomes the new bottom row, blank it
                    r_top_off   <= top_next;
                    r_fill_addr <= rb_next;
                    r_fill_left <= FW'(COLS);
                end else begin
                    r_row <= RW'(r_row + 1'b1);
                end
            end else if (i_cmd.store) begin
                r_col <= CW'(r_col + 1'b1);
                r_ph  <= ph_inc;
            end
            if (i_cmd.col_home) begin
                r_col <= '0;
                r_ph  <= '0;
            end
            if (i_cmd.col_dec) begin
                r_col <= CW'(r_col - 1'b1);
                r_ph  <= ph_dec;
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_cmd.out_take) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.req       = r_item.req_type;
    assign o_sts.is_nl     = (r_item.char_code == CH_NEWLINE);
    assign o_sts.is_cr     = (r_item.char_code == CH_RETURN);
    assign o_sts.is_bs     = (r_item.char_code == CH_BACK);
    assign o_sts.is_tab    = (r_item.req_type == REQ_PUT) && (r_item.char_code == CH_TAB);
    assign o_sts.col_zero  = (r_col == '0);
    assign o_sts.col_last  = col_last;
    assign o_sts.row_last  = row_last;
    assign o_sts.tab_last  = (r_tab_left == TW'(1));
    assign o_sts.tab_more  = (r_tab_left != '0);
    assign o_sts.fill_last = (r_fill_left == FW'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (CW+1)'(COLS)) && ({1'b0, r_row} < (RW+1)'(ROWS)))
        else $error("cursor outside the screen");

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row_base} < (AW+1)'(CELLS)) && ({1'b0, r_top_off} < (AW+1)'(CELLS)))
        else $error("row ring pointer out of range");

    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result loaded over a pending beat");

    a_scroll_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_adv && row_last) |=> (r_fill_addr == r_row_base))
        else $error("scroll fill does not start at the new bottom row");

endmodule

// File: src/text_console_cell_writer_core.sv
// An input beat is captured and decoded, then any cells are written (the code itself, a blanked
// backspace cell, one space per tab step, the bottom row on each scroll), then the result is
// registered. One item at a time: the next beat is taken only after the result leaves and the
// controller is back in idle, set by the single write port and the stepping controller; a clear
// sweeps every cell first. Reset (synchronous, active low) homes the cursor, then sweeps the
// memory to spaces in color 0x0F, one cell a cycle, input stalled meanwhile.
module text_console_cell_writer_core import tccw_pkg::*; #(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    tccw_dpath #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data)
    );

endmodule

// File: test/text_console_cell_writer_core_test.sv
module text_console_cell_writer_core_test import tccw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS      = 80;
    localparam int NROWS      = 25;
    localparam int NCELLS     = NCOLS * NROWS;
    localparam int TAB_WIDTH  = 4;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_BEATS   = 850;
    localparam int IDLE_PCT       = 31;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 20000;

    // Predicts cursor and cell contents and keeps the results still owed by the block.
    class console_scoreboard;
        logic [7:0] glyph_mem [NCELLS];
        logic [7:0] attr_mem [NCELLS];
        int unsigned col;
        int unsigned row;
        t_out_item expected_q[$];
        int fail_count;
        int report_count;
        int results_seen;

        function new();
            fill_screen(RESET_COLOR);
            fail_count   = 0;
            report_count = 0;
            results_seen = 0;
        endfunction

        function void fill_screen(logic [7:0] attr);
            for (int i = 0; i < NCELLS; i++) begin
                glyph_mem[i] = CH_SPACE;
                attr_mem[i]  = attr;
            end
            col = 0;
            row = 0;
        endfunction

        function void next_line(logic [7:0] attr);
            col = 0;
            if (row + 1 >= NROWS) begin
                // scroll up one row, blank the bottom row in this beat's color
                for (int i = 0; i < NCELLS - NCOLS; i++) begin
                    glyph_mem[i] = glyph_mem[i + NCOLS];
                    attr_mem[i]  = attr_mem[i + NCOLS];
                end
                for (int i = NCELLS - NCOLS; i < NCELLS; i++) begin
                    glyph_mem[i] = CH_SPACE;
                    attr_mem[i]  = attr;
                end
                row = NROWS - 1;
            end else begin
                row++;
            end
        endfunction

        function void write_cell(logic [7:0] ch, logic [7:0] attr);
            int unsigned pos;
            pos = row * NCOLS + col;
            glyph_mem[pos] = ch;
            attr_mem[pos]  = attr;
            col++;
            if (col >= NCOLS) begin
                next_line(attr);
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item want;
            int unsigned spaces;
            want.read_char  = 8'h00;
            want.read_color = 8'h00;
            case (it.req_type)
                REQ_PUT: begin
                    case (it.char_code)
                        CH_NEWLINE: next_line(it.text_color);
                        CH_RETURN:  col = 0;
                        CH_BACK: begin
                            if (col > 0) begin
                                col--;
                                glyph_mem[row * NCOLS + col] = CH_SPACE;
                            end
                        end
                        CH_TAB: begin
                            spaces = TAB_WIDTH - (col % TAB_WIDTH);
                            repeat (spaces) write_cell(CH_SPACE, it.text_color);
                        end
                        default: write_cell(it.char_code, it.text_color);
                    endcase
                end
                REQ_CLEAR: fill_screen(it.text_color);
                REQ_READ: begin
                    if (it.cell_index < NCELLS) begin
                        want.read_char  = glyph_mem[it.cell_index];
                        want.read_color = attr_mem[it.cell_index];
                    end
                end
                default: ;
            endcase
            want.cursor_col = 7'(col);
            want.cursor_row = 5'(row);
            expected_q.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_q.size() == 0) begin
                fail_count++;
                report_count++;
                if (report_count <= 10) begin
                    $display("unexpected result beat: col %0d row %0d char %02h color %02h",
                             got.cursor_col, got.cursor_row, got.read_char, got.read_color);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
                got.read_char !== want.read_char || got.read_color !== want.read_color) begin
                fail_count++;
                report_count++;
                if (report_count <= 10) begin
                    $display("mismatch at result %0d: expected col %0d row %0d char %02h color %02h, got col %0d row %0d char %02h color %02h",
                             results_seen, want.cursor_col, want.cursor_row, want.read_char,
                             want.read_color, got.cursor_col, got.cursor_row, got.read_char,
                             got.read_color);
                end
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    console_scoreboard sb;
    logic send_calm = 1'b0;
    int   quiet_cycles = 0;

    text_console_cell_writer_core #(
        .COLS     (NCOLS),
        .ROWS     (NROWS),
        .TAB_STOP (TAB_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input t_in_item it);
        while (!send_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [1:0] req, input logic [7:0] ch,
                               input logic [7:0] attr, input logic [10:0] idx);
        t_in_item it;
        it.req_type   = req;
        it.char_code  = ch;
        it.text_color = attr;
        it.cell_index = idx;
        send_item(it);
    endtask

    // phase 0: ordinary text, 1: long lines that wrap, 2: many newlines and scrolls
    function automatic t_in_item make_random(int unsigned phase);
        t_in_item it;
        int unsigned r;
        int unsigned nl_pct;
        int unsigned pos;
        it.req_type   = REQ_PUT;
        it.char_code  = 8'($urandom_range(0, 255));
        it.text_color = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 2047));
        r = $urandom_range(0, 999);
        if (r < 4) begin
            it.req_type = REQ_CLEAR;
        end else if (r < 9) begin
            it.req_type = REQ_UNUSED;
        end else if (r < 200) begin
            it.req_type = REQ_READ;
            if ($urandom_range(0, 1) == 1) begin
                // look just behind the cursor where fresh cells sit
                pos = sb.row * NCOLS + sb.col;
                if (pos >= 8) begin
                    pos = pos - $urandom_range(0, 8);
                end
                it.cell_index = 11'(pos);
            end
        end else begin
            nl_pct = (phase == 1) ? 1 : (phase == 2) ? 30 : 8;
            r = $urandom_range(0, 99);
            if (r < nl_pct) begin
                it.char_code = CH_NEWLINE;
            end else if (r < nl_pct + 3) begin
                it.char_code = CH_RETURN;
            end else if (r < nl_pct + 9) begin
                it.char_code = CH_BACK;
            end else if (r < nl_pct + 15) begin
                it.char_code = CH_TAB;
            end
        end
        return it;
    endfunction

    // result side: random stall, one long hold-off, one calm stretch
    initial begin
        bit hold_done;
        bit calm;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && sb.results_seen >= 250) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            calm = (sb.results_seen >= 420 && sb.results_seen < 560);
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset contents, range ends, unused request type
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd0);
        send_fields(REQ_READ, 8'hFF, 8'hFF, 11'(NCELLS - 1));
        send_fields(REQ_READ, 8'h00, 8'h00, 11'(NCELLS));
        send_fields(REQ_READ, 8'hFF, 8'hFF, 11'h7FF);
        send_fields(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
        // code zero and all-ones stored as plain characters
        send_fields(REQ_PUT, 8'h00, 8'h00, 11'd0);
        send_fields(REQ_PUT, 8'hFF, 8'hFF, 11'd0);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd0);
        // backspace blanks the glyph and keeps the color
        send_fields(REQ_PUT, CH_BACK, 8'h00, 11'd0);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd1);
        send_fields(REQ_PUT, CH_RETURN, 8'h33, 11'd0);
        send_fields(REQ_PUT, CH_BACK, 8'h44, 11'd0);
        send_fields(REQ_PUT, CH_TAB, 8'h71, 11'd0);
        send_fields(REQ_PUT, 8'h41, 8'h1E, 11'd0);
        send_fields(REQ_PUT, CH_TAB, 8'h72, 11'd0);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd7);
        send_fields(REQ_PUT, CH_NEWLINE, 8'h5A, 11'd0);
        // clear in color zero, then check both ends
        send_fields(REQ_CLEAR, 8'h00, 8'h00, 11'd0);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'(NCELLS - 1));
        send_fields(REQ_PUT, 8'h5A, 8'h81, 11'd0);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd0);
        send_fields(REQ_CLEAR, 8'hFF, 8'hA5, 11'h7FF);
        send_fields(REQ_READ, 8'h00, 8'h00, 11'd1000);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            send_calm = (n >= 400 && n < 550);
            if (n == 600) begin
                // let the block drain completely before going on
                in_valid <= 1'b0;
                do @(negedge clk); while (sb.expected_q.size() != 0);
            end
            send_item(make_random(((n / 100) + 1) % 3));
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
src/tccw_pkg.sv
src/tccw_ctrl.sv
src/tccw_dpath.sv
src/text_console_cell_writer_core.sv
test/text_console_cell_writer_core_test.sv
